/* src/pbrain_instruction_executor_macros.svh */
// assertion helpers used by the executor control module
`ifndef PBRAIN_INSTRUCTION_EXECUTOR_MACROS_SVH
`define PBRAIN_INSTRUCTION_EXECUTOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PBIE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pbie check failed");

// next-cycle implication
`define PBIE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pbie check failed");

`endif

/* src/pbie_pkg.sv */
package pbie_pkg;

	// default sizes
	localparam int PROG_DEPTH_DEF  = 4096;
	localparam int DATA_DEPTH_DEF  = 65536;
	localparam int STACK_DEPTH_DEF = 256;
	localparam int PROC_SLOTS      = 256;

	// program counter and length width
	localparam int PC_W = 13;

	// instruction characters
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COLON  = 8'h3A;

	// what the execute cycle asks for next
	typedef enum logic [1:0] {
		KIND_DONE,
		KIND_SCAN,
		KIND_CALL
	} exec_kind_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic fetch;
		logic exec;
		logic scan;
		logic scan_take;
		logic scan_fault;
		logic call;
		logic pop_commit;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       clr_last;
		logic       runnable;
		exec_kind_t kind;
		logic       scan_found;
		logic       scan_fail;
		logic       scan_pop;
	} status_t;

endpackage

/* src/pbrain_instruction_executor.sv */
// pbrain instruction executor
// input channel (in_valid / in_stall): one word per item; mode 0 writes
// load_byte to the program store at load_address, mode 1 runs the
// instruction at the program counter, using console_byte / console_eof
// for the comma instruction.
// output channel (out_valid / out_stall): exactly one word per input word,
// in order, with emit, console, halt and fault status and the new pc.
// config channel (cfg_valid / cfg_ready): program_length, write only while
// the block is idle; cfg_ready is always high.
// flow: items are handled one at a time. a load or a skipped step goes
// from accept straight to the done state; an instruction passes fetch and
// execute, a call adds a call state, and a bracket or paren that skips
// scans the program store byte by byte through its single read port,
// with a pop state more when a close paren returns through the stack. the
// next item is taken once its result is loaded and the block is idle.
// reset: all control state clears, then the data cells are swept to zero
// at one cell per cycle, with in_stall held high.
// a stalled output word holds; the next item is still accepted and runs,
// and its result waits until the output register frees.
module pbrain_instruction_executor #(
	parameter int PROG_DEPTH  = pbie_pkg::PROG_DEPTH_DEF,
	parameter int DATA_DEPTH  = pbie_pkg::DATA_DEPTH_DEF,
	parameter int STACK_DEPTH = pbie_pkg::STACK_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      mode,
	input  logic [11:0]               load_address,
	input  logic [7:0]                load_byte,
	input  logic [7:0]                console_byte,
	input  logic                      console_eof,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      emit_valid,
	output logic [7:0]                emit_byte,
	output logic                      console_taken,
	output logic                      halted,
	output logic                      fault,
	output logic [pbie_pkg::PC_W-1:0] program_counter,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [pbie_pkg::PC_W-1:0] program_length
);

	pbie_pkg::cmd_t    cmd;
	pbie_pkg::status_t st;

	// register write is always taken
	assign cfg_ready = 1'b1;

	pbie_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.st        (st)
	);

	pbie_datapath #(
		.PROG_DEPTH  (PROG_DEPTH),
		.DATA_DEPTH  (DATA_DEPTH),
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.mode            (mode),
		.load_address    (load_address),
		.load_byte       (load_byte),
		.console_byte    (console_byte),
		.console_eof     (console_eof),
		.cfg_we          (cfg_valid),
		.cfg_data        (program_length),
		.emit_valid      (emit_valid),
		.emit_byte       (emit_byte),
		.console_taken   (console_taken),
		.halted          (halted),
		.fault           (fault),
		.program_counter (program_counter)
	);

endmodule

/* src/pbie_datapath.sv */
module pbie_datapath #(
	parameter int PROG_DEPTH  = pbie_pkg::PROG_DEPTH_DEF,
	parameter int DATA_DEPTH  = pbie_pkg::DATA_DEPTH_DEF,
	parameter int STACK_DEPTH = pbie_pkg::STACK_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pbie_pkg::cmd_t          cmd,
	output pbie_pkg::status_t       st,
	input  logic                    mode,
	input  logic [11:0]             load_address,
	input  logic [7:0]              load_byte,
	input  logic [7:0]              console_byte,
	input  logic                    console_eof,
	input  logic                    cfg_we,
	input  logic [pbie_pkg::PC_W-1:0] cfg_data,
	output logic                    emit_valid,
	output logic [7:0]              emit_byte,
	output logic                    console_taken,
	output logic                    halted,
	output logic                    fault,
	output logic [pbie_pkg::PC_W-1:0] program_counter
);

	localparam int PC_W = pbie_pkg::PC_W;
	localparam int PA_W = $clog2(PROG_DEPTH);
	localparam int DP_W = $clog2(DATA_DEPTH);
	localparam int SA_W = $clog2(STACK_DEPTH);
	localparam int SL_W = $clog2(STACK_DEPTH + 1);

	// storage
	logic [7:0]      prog_mem  [PROG_DEPTH];
	logic [7:0]      cell_mem  [DATA_DEPTH];
	logic [PC_W-1:0] proc_mem  [pbie_pkg::PROC_SLOTS];
	logic [PC_W-1:0] stack_mem [STACK_DEPTH];

	// architectural state
	logic [PC_W-1:0] prog_len_q;
	logic [PC_W-1:0] pc_q;
	logic [DP_W-1:0] dp_q;
	logic            stopped_q;
	logic [SL_W-1:0] level_q;
	logic [pbie_pkg::PROC_SLOTS-1:0] proc_vld_q;
	logic [DP_W-1:0] clr_cnt_q;

	// per-item registers
	logic [7:0]      cbyte_q;
	logic            eof_q;
	logic            emit_q;
	logic [7:0]      emit_byte_q;
	logic            taken_q;
	logic [7:0]      prog_rd_q;
	logic [7:0]      cell_rd_q;
	logic [PC_W-1:0] proc_rd_q;
	logic            proc_hit_q;
	logic [PC_W-1:0] stack_rd_q;

	// bracket scan
	logic [PC_W:0]   ptr_q;
	logic [PC_W:0]   depth_q;
	logic            fwd_q;
	logic [7:0]      same_q;
	logic [7:0]      partner_q;
	logic            close_paren_q;
	logic            hit_s1;
	logic [PC_W:0]   at_s1;

	logic [PC_W-1:0] len;
	logic            inb;
	logic            issue;
	logic            found;
	logic            prog_we;
	logic            prog_re;
	logic [PA_W-1:0] prog_ra;
	logic            cell_we;
	logic [DP_W-1:0] cell_wa;
	logic [7:0]      cell_wd;
	logic            push;
	logic            pop_rd;

	// execute decode
	logic            ex_cell_we;
	logic [7:0]      ex_cell_wd;
	logic [DP_W-1:0] ex_dp_nxt;
	logic            ex_emit;
	logic            ex_taken;
	logic            ex_scan;
	logic            ex_fwd;
	logic [7:0]      ex_same;
	logic [7:0]      ex_partner;
	logic            ex_def;
	logic            ex_call;

	// effective program length
	assign len = (32'(prog_len_q) < PROG_DEPTH) ? prog_len_q : PC_W'(PROG_DEPTH);

	// scan bounds and match
	assign inb   = fwd_q ? (ptr_q < {1'b0, len}) : !ptr_q[PC_W];
	assign issue = cmd.scan && inb;
	assign found = hit_s1 && (prog_rd_q == partner_q) && (depth_q == (PC_W+1)'(1));

	// decode of the fetched instruction
	always_comb begin
		ex_cell_we = 1'b0;
		ex_cell_wd = cell_rd_q;
		ex_dp_nxt  = dp_q;
		ex_emit    = 1'b0;
		ex_taken   = 1'b0;
		ex_scan    = 1'b0;
		ex_fwd     = 1'b1;
		ex_same    = pbie_pkg::CH_LBRACK;
		ex_partner = pbie_pkg::CH_RBRACK;
		ex_def     = 1'b0;
		ex_call    = 1'b0;
		case (prog_rd_q)
			pbie_pkg::CH_PLUS: begin
				ex_cell_we = 1'b1;
				ex_cell_wd = cell_rd_q + 8'd1;
			end
			pbie_pkg::CH_MINUS: begin
				ex_cell_we = 1'b1;
				ex_cell_wd = cell_rd_q - 8'd1;
			end
			pbie_pkg::CH_LT: begin
				ex_dp_nxt = (dp_q == '0) ? DP_W'(DATA_DEPTH - 1) : dp_q - DP_W'(1);
			end
			pbie_pkg::CH_GT: begin
				ex_dp_nxt = (dp_q == DP_W'(DATA_DEPTH - 1)) ? '0 : dp_q + DP_W'(1);
			end
			pbie_pkg::CH_DOT: begin
				ex_emit = 1'b1;
			end
			pbie_pkg::CH_COMMA: begin
				ex_cell_we = 1'b1;
				ex_cell_wd = eof_q ? 8'd0 : cbyte_q;
				ex_taken   = !eof_q;
			end
			pbie_pkg::CH_LBRACK: begin
				ex_scan = (cell_rd_q == 8'd0);
			end
			pbie_pkg::CH_RBRACK: begin
				ex_scan    = (cell_rd_q != 8'd0);
				ex_fwd     = 1'b0;
				ex_same    = pbie_pkg::CH_RBRACK;
				ex_partner = pbie_pkg::CH_LBRACK;
			end
			pbie_pkg::CH_LPAREN: begin
				ex_def     = 1'b1;
				ex_scan    = 1'b1;
				ex_same    = pbie_pkg::CH_LPAREN;
				ex_partner = pbie_pkg::CH_RPAREN;
			end
			pbie_pkg::CH_RPAREN: begin
				ex_scan    = 1'b1;
				ex_fwd     = 1'b0;
				ex_same    = pbie_pkg::CH_RPAREN;
				ex_partner = pbie_pkg::CH_LPAREN;
			end
			pbie_pkg::CH_COLON: begin
				ex_call = (level_q != SL_W'(STACK_DEPTH));
			end
			default: begin
			end
		endcase
	end

	// status to controller
	always_comb begin
		st.clr_last   = (clr_cnt_q == DP_W'(DATA_DEPTH - 1));
		st.runnable   = !stopped_q && (pc_q < len);
		st.kind       = ex_scan ? pbie_pkg::KIND_SCAN :
				ex_call ? pbie_pkg::KIND_CALL : pbie_pkg::KIND_DONE;
		st.scan_found = found;
		st.scan_fail  = !hit_s1 && !inb;
		st.scan_pop   = close_paren_q && (level_q != '0);
	end

	// program store port
	assign prog_we = cmd.accept && !mode && (32'(load_address) < PROG_DEPTH);
	assign prog_re = cmd.fetch || issue;
	assign prog_ra = cmd.fetch ? PA_W'(pc_q) : PA_W'(ptr_q[PC_W-1:0]);

	always_ff @(posedge clk) begin
		if (prog_we) begin
			prog_mem[PA_W'(load_address)] <= load_byte;
		end
		if (prog_re) begin
			prog_rd_q <= prog_mem[prog_ra];
		end
	end

	// data cell port, also swept to zero after reset
	assign cell_we = cmd.clear || (cmd.exec && ex_cell_we);
	assign cell_wa = cmd.clear ? clr_cnt_q : dp_q;
	assign cell_wd = cmd.clear ? 8'd0 : ex_cell_wd;

	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[cell_wa] <= cell_wd;
		end
		if (cmd.fetch) begin
			cell_rd_q <= cell_mem[dp_q];
		end
	end

	// procedure entry store
	always_ff @(posedge clk) begin
		if (cmd.exec && ex_def) begin
			proc_mem[cell_rd_q] <= pc_q;
		end
		if (cmd.exec && ex_call) begin
			proc_rd_q <= proc_mem[cell_rd_q];
		end
	end

	// return stack
	assign push   = cmd.exec && ex_call;
	assign pop_rd = cmd.scan_take && close_paren_q && (level_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			stack_mem[SA_W'(level_q)] <= pc_q;
		end
		if (pop_rd) begin
			stack_rd_q <= stack_mem[SA_W'(level_q - SL_W'(1))];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_len_q <= '0;
			pc_q       <= '0;
			dp_q       <= '0;
			stopped_q  <= 1'b0;
			level_q    <= '0;
			proc_vld_q <= '0;
			clr_cnt_q  <= '0;
			hit_s1     <= 1'b0;
		end else begin
			if (cfg_we) begin
				prog_len_q <= cfg_data;
			end
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + DP_W'(1);
			end
			if (cmd.exec) begin
				dp_q <= ex_dp_nxt;
				if (!ex_scan && !ex_call) begin
					pc_q <= pc_q + PC_W'(1);
				end
				if (ex_call) begin
					level_q <= level_q + SL_W'(1);
				end
				if (ex_def) begin
					proc_vld_q[cell_rd_q] <= 1'b1;
				end
			end
			hit_s1 <= issue;
			if (cmd.scan_take) begin
				if (pop_rd) begin
					level_q <= level_q - SL_W'(1);
				end else begin
					pc_q <= at_s1[PC_W-1:0] + PC_W'(1);
				end
			end
			if (cmd.scan_fault) begin
				stopped_q <= 1'b1;
			end
			if (cmd.call) begin
				pc_q <= proc_hit_q ? proc_rd_q + PC_W'(1) : '0;
			end
			if (cmd.pop_commit) begin
				pc_q <= stack_rd_q + PC_W'(1);
			end
		end
	end

	// per-item payload, scan and output registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cbyte_q     <= console_byte;
			eof_q       <= console_eof;
			emit_q      <= 1'b0;
			emit_byte_q <= 8'd0;
			taken_q     <= 1'b0;
		end
		if (cmd.exec) begin
			emit_q        <= ex_emit;
			emit_byte_q   <= ex_emit ? cell_rd_q : 8'd0;
			taken_q       <= ex_taken;
			proc_hit_q    <= proc_vld_q[cell_rd_q];
			ptr_q         <= ex_fwd ? {1'b0, pc_q} + (PC_W+1)'(1) : {1'b0, pc_q} - (PC_W+1)'(1);
			depth_q       <= (PC_W+1)'(1);
			fwd_q         <= ex_fwd;
			same_q        <= ex_same;
			partner_q     <= ex_partner;
			close_paren_q <= (prog_rd_q == pbie_pkg::CH_RPAREN);
		end
		if (issue) begin
			at_s1 <= ptr_q;
			ptr_q <= fwd_q ? ptr_q + (PC_W+1)'(1) : ptr_q - (PC_W+1)'(1);
		end
		if (cmd.scan && hit_s1 && !found) begin
			if (prog_rd_q == same_q) begin
				depth_q <= depth_q + (PC_W+1)'(1);
			end else if (prog_rd_q == partner_q) begin
				depth_q <= depth_q - (PC_W+1)'(1);
			end
		end
		if (cmd.out_load) begin
			emit_valid      <= emit_q;
			emit_byte       <= emit_byte_q;
			console_taken   <= taken_q;
			halted          <= stopped_q || !(pc_q < len);
			fault           <= stopped_q;
			program_counter <= pc_q;
		end
	end

endmodule

/* src/pbie_ctrl.sv */
`include "pbrain_instruction_executor_macros.svh"

module pbie_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	output logic              out_valid,
	input  logic              out_stall,
	output pbie_pkg::cmd_t    cmd,
	input  pbie_pkg::status_t st
);

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_FETCH = 8'b0000_0100,
		ST_EXEC  = 8'b0000_1000,
		ST_SCAN  = 8'b0001_0000,
		ST_CALL  = 8'b0010_0000,
		ST_POP   = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (st.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = (mode && st.runnable) ? ST_FETCH : ST_DONE;
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				case (st.kind)
					pbie_pkg::KIND_SCAN: state_nxt = ST_SCAN;
					pbie_pkg::KIND_CALL: state_nxt = ST_CALL;
					default:             state_nxt = ST_DONE;
				endcase
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_found) begin
					cmd.scan_take = 1'b1;
					state_nxt     = st.scan_pop ? ST_POP : ST_DONE;
				end else if (st.scan_fail) begin
					cmd.scan_fault = 1'b1;
					state_nxt      = ST_DONE;
				end
			end
			ST_CALL: begin
				cmd.call  = 1'b1;
				state_nxt = ST_DONE;
			end
			ST_POP: begin
				cmd.pop_commit = 1'b1;
				state_nxt      = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state and output word flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// checks
	`PBIE_ASSERT_NEXT(a_accept_leaves_idle, cmd.accept, state_q != ST_IDLE)
	`PBIE_ASSERT_SAME(a_scan_excl, (state_q == ST_SCAN) && st.scan_found, !st.scan_fail)
	`PBIE_ASSERT_SAME(a_load_when_free, cmd.out_load, !out_valid_q || !out_stall)

endmodule

/* tb/tb_pbrain_instruction_executor.sv */
`timescale 1ns / 100ps

module tb_pbrain_instruction_executor;

	localparam int PDEPTH = 4096;
	localparam int DDEPTH = 65536;
	localparam int SDEPTH = 256;

	typedef struct packed {
		logic        emit_valid;
		logic [7:0]  emit_byte;
		logic        console_taken;
		logic        halted;
		logic        fault;
		logic [12:0] pc;
	} step_word_t;

	typedef struct {
		logic       mode;
		logic [11:0] addr;
		logic [7:0] lbyte;
		logic [7:0] cbyte;
		logic       eof;
		logic       typed;
		step_word_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        mode;
	logic [11:0] load_address;
	logic [7:0]  load_byte;
	logic [7:0]  console_byte;
	logic        console_eof;
	logic        out_valid;
	logic        out_stall;
	logic        emit_valid;
	logic [7:0]  emit_byte;
	logic        console_taken;
	logic        halted;
	logic        fault;
	logic [pbie_pkg::PC_W-1:0] program_counter;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [pbie_pkg::PC_W-1:0] program_length;

	pbrain_instruction_executor u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .load_address(load_address), .load_byte(load_byte),
		.console_byte(console_byte), .console_eof(console_eof),
		.out_valid(out_valid), .out_stall(out_stall),
		.emit_valid(emit_valid), .emit_byte(emit_byte),
		.console_taken(console_taken), .halted(halted), .fault(fault),
		.program_counter(program_counter),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.program_length(program_length)
	);

	// machine mirror
	logic [7:0]  prog_mem [PDEPTH];
	logic [7:0]  cell_mem [DDEPTH];
	int          dptr;
	int          pc_now;
	logic        proc_def [256];
	int          proc_at [256];
	int          ret_stack [SDEPTH];
	int          sp_level;
	logic        stopped;
	int          len_reg;

	step_word_t  pending_words[$];
	int          mismatches;
	int          exec_count, load_count, emit_count, deepest;
	logic        quiet;
	int          prog_end;

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic want_idle();
		return !quiet && ($urandom_range(0, 99) < 26);
	endfunction

	function automatic int eff_len();
		return (len_reg < PDEPTH) ? len_reg : PDEPTH;
	endfunction

	function automatic logic seek_fwd(logic [7:0] opn, logic [7:0] cls, int from, int lim,
			output int at);
		int depth;
		depth = 1;
		at = 0;
		for (int i = from + 1; i < lim; i++) begin
			if (prog_mem[i] == opn) depth++;
			else if (prog_mem[i] == cls) begin
				depth--;
				if (depth == 0) begin
					at = i;
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic logic seek_back(logic [7:0] opn, logic [7:0] cls, int from,
			output int at);
		int depth;
		depth = 1;
		at = 0;
		for (int i = from - 1; i >= 0; i--) begin
			if (prog_mem[i] == cls) depth++;
			else if (prog_mem[i] == opn) begin
				depth--;
				if (depth == 0) begin
					at = i;
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	// advance the mirror by one word and return the status it produces
	function automatic step_word_t run_step(logic m, logic [11:0] a, logic [7:0] lb,
			logic [7:0] cb, logic eof);
		step_word_t w;
		int lim, nxt, at;
		logic bad;
		logic [7:0] cur;
		w = '0;
		lim = eff_len();
		bad = 1'b0;
		if (!m) begin
			prog_mem[a] = lb;
			load_count++;
		end else if (!stopped && pc_now < lim) begin
			exec_count++;
			nxt = pc_now + 1;
			cur = cell_mem[dptr];
			case (prog_mem[pc_now])
				pbie_pkg::CH_PLUS:  cell_mem[dptr] = cur + 8'd1;
				pbie_pkg::CH_MINUS: cell_mem[dptr] = cur - 8'd1;
				pbie_pkg::CH_LT:    dptr = (dptr == 0) ? DDEPTH - 1 : dptr - 1;
				pbie_pkg::CH_GT:    dptr = (dptr + 1 >= DDEPTH) ? 0 : dptr + 1;
				pbie_pkg::CH_DOT: begin
					w.emit_valid = 1'b1;
					w.emit_byte = cur;
					emit_count++;
				end
				pbie_pkg::CH_COMMA: begin
					if (eof) cell_mem[dptr] = 8'd0;
					else begin
						cell_mem[dptr] = cb;
						w.console_taken = 1'b1;
					end
				end
				pbie_pkg::CH_LBRACK: begin
					if (cur == 0) begin
						if (seek_fwd(pbie_pkg::CH_LBRACK, pbie_pkg::CH_RBRACK, pc_now, lim,
								at)) nxt = at + 1;
						else bad = 1'b1;
					end
				end
				pbie_pkg::CH_RBRACK: begin
					if (cur != 0) begin
						if (seek_back(pbie_pkg::CH_LBRACK, pbie_pkg::CH_RBRACK, pc_now, at))
							nxt = at + 1;
						else bad = 1'b1;
					end
				end
				pbie_pkg::CH_LPAREN: begin
					proc_def[cur] = 1'b1;
					proc_at[cur] = pc_now;
					if (seek_fwd(pbie_pkg::CH_LPAREN, pbie_pkg::CH_RPAREN, pc_now, lim, at))
						nxt = at + 1;
					else bad = 1'b1;
				end
				pbie_pkg::CH_RPAREN: begin
					if (!seek_back(pbie_pkg::CH_LPAREN, pbie_pkg::CH_RPAREN, pc_now, at))
						bad = 1'b1;
					else if (sp_level > 0) begin
						sp_level--;
						nxt = ret_stack[sp_level] + 1;
					end else nxt = at + 1;
				end
				pbie_pkg::CH_COLON: begin
					if (sp_level < SDEPTH) begin
						ret_stack[sp_level] = pc_now;
						sp_level++;
						if (sp_level > deepest) deepest = sp_level;
						nxt = proc_def[cur] ? proc_at[cur] + 1 : 0;
					end
				end
				default: ;
			endcase
			if (bad) stopped = 1'b1;
			else pc_now = nxt;
		end
		w.halted = stopped || (pc_now >= lim);
		w.fault = stopped;
		w.pc = pc_now[12:0];
		return w;
	endfunction

	// present one word; the expectation is queued at the accepting edge
	task automatic send_word(stim_row_t r);
		step_word_t w;
		if (want_idle()) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 4)) @(negedge clk);
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		mode         <= r.mode;
		load_address <= r.addr;
		load_byte    <= r.lbyte;
		console_byte <= r.cbyte;
		console_eof  <= r.eof;
		do @(posedge clk); while (in_stall);
		w = run_step(r.mode, r.addr, r.lbyte, r.cbyte, r.eof);
		pending_words.push_back(r.typed ? r.want : w);
	endtask

	task automatic load_word(int a, logic [7:0] b);
		stim_row_t r;
		r = '{1'b0, a[11:0], b, 8'($urandom), 1'($urandom), 1'b0, '0};
		send_word(r);
	endtask

	task automatic exec_word();
		stim_row_t r;
		r = '{1'b1, 12'($urandom), 8'($urandom), 8'($urandom),
			($urandom_range(0, 99) < 20), 1'b0, '0};
		send_word(r);
	endtask

	// length write, only once the block has drained
	task automatic set_length(int v);
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_words.size() == 0);
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_valid      <= 1'b1;
		program_length <= v[12:0];
		do @(posedge clk); while (!cfg_ready);
		len_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// well-nested random code appended at prog_end
	task automatic append_code(int n);
		logic [7:0] ops [7];
		logic [7:0] open_stk [$];
		logic [7:0] ch;
		int k;
		ops = '{pbie_pkg::CH_PLUS, pbie_pkg::CH_MINUS, pbie_pkg::CH_LT, pbie_pkg::CH_GT,
			pbie_pkg::CH_DOT, pbie_pkg::CH_COMMA, pbie_pkg::CH_COLON};
		for (int i = 0; i < n || open_stk.size() > 0; i++) begin
			k = $urandom_range(0, 99);
			if (i < n && k < 12 && open_stk.size() < 4) begin
				ch = ($urandom_range(0, 1) != 0) ? pbie_pkg::CH_LBRACK : pbie_pkg::CH_LPAREN;
				open_stk.push_back(ch);
			end else if (open_stk.size() > 0 && (k < 26 || i >= n)) begin
				ch = (open_stk.pop_back() == pbie_pkg::CH_LBRACK) ? pbie_pkg::CH_RBRACK :
					pbie_pkg::CH_RPAREN;
			end else if (k < 90) begin
				ch = ops[$urandom_range(0, 6)];
			end else begin
				do ch = 8'($urandom);
				while (ch == pbie_pkg::CH_LBRACK || ch == pbie_pkg::CH_RBRACK
					|| ch == pbie_pkg::CH_LPAREN || ch == pbie_pkg::CH_RPAREN);
			end
			if (prog_end < PDEPTH) begin
				load_word(prog_end, ch);
				prog_end++;
			end
		end
	endtask

	// run until halted, with a cap for loops that do not end
	task automatic run_steps(int cap);
		for (int i = 0; i < cap; i++) begin
			exec_word();
			if (stopped || pc_now >= eff_len()) begin
				exec_word();
				break;
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin
		step_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				$error("result word with nothing expected");
				mismatches++;
			end else begin
				e = pending_words.pop_front();
				if (emit_valid !== e.emit_valid) begin
					$error("emit_valid exp %0d got %0d", e.emit_valid, emit_valid);
					mismatches++;
				end
				if (emit_byte !== e.emit_byte) begin
					$error("emit_byte exp %0h got %0h", e.emit_byte, emit_byte);
					mismatches++;
				end
				if (console_taken !== e.console_taken) begin
					$error("console_taken exp %0d got %0d", e.console_taken, console_taken);
					mismatches++;
				end
				if (halted !== e.halted) begin
					$error("halted exp %0d got %0d", e.halted, halted);
					mismatches++;
				end
				if (fault !== e.fault) begin
					$error("fault exp %0d got %0d", e.fault, fault);
					mismatches++;
				end
				if (program_counter !== e.pc) begin
					$error("program_counter exp %0d got %0d", e.pc, program_counter);
					mismatches++;
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		out_stall <= want_idle();
	end

	// stimulus
	initial begin
		stim_row_t rows_a [$];
		stim_row_t rows_b [$];
		string     code;
		step_word_t idle_w;
		int        lim, f;
		mismatches = 0;
		exec_count = 0;
		load_count = 0;
		emit_count = 0;
		deepest = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = 1'b0;
		load_address = '0;
		load_byte = '0;
		console_byte = '0;
		console_eof = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		program_length = '0;
		foreach (prog_mem[i]) prog_mem[i] = 8'd0;
		foreach (cell_mem[i]) cell_mem[i] = 8'd0;
		foreach (proc_def[i]) proc_def[i] = 1'b0;
		foreach (proc_at[i]) proc_at[i] = 0;
		dptr = 0;
		pc_now = 0;
		sp_level = 0;
		stopped = 1'b0;
		len_reg = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero length: everything reports halted at pc 0
		idle_w = '{1'b0, 8'd0, 1'b0, 1'b1, 1'b0, 13'd0};
		rows_a.push_back('{1'b1, 12'hfff, 8'hff, 8'hff, 1'b0, 1'b1, idle_w});
		rows_a.push_back('{1'b0, 12'hfff, 8'hff, 8'h00, 1'b1, 1'b1, idle_w});
		rows_a.push_back('{1'b0, 12'h000, 8'h00, 8'hff, 1'b0, 1'b1, idle_w});
		code = "-.+<.>,.,.";
		for (int i = 0; i < code.len(); i++)
			rows_a.push_back('{1'b0, 12'(i), code[i], 8'h00, 1'b0, 1'b1, idle_w});
		foreach (rows_a[i]) send_word(rows_a[i]);
		set_length(code.len());
		prog_end = code.len();

		// wrap of cell and pointer, console with and without data, then halted
		for (int i = 0; i < code.len(); i++)
			rows_b.push_back('{1'b1, 12'h000, 8'h00, (i == 6) ? 8'ha5 : 8'hff,
				(i == 8), 1'b0, '0});
		rows_b.push_back('{1'b1, 12'h000, 8'h00, 8'h00, 1'b0, 1'b1,
			'{1'b0, 8'd0, 1'b0, 1'b1, 1'b0, 13'd10}});
		foreach (rows_b[i]) send_word(rows_b[i]);

		// self-calling procedure fills the return stack, then unwinds
		quiet = 1'b1;
		code = "(:):";
		for (int i = 0; i < code.len(); i++) load_word(prog_end + i, code[i]);
		prog_end += code.len();
		set_length(prog_end);
		run_steps(600);
		quiet = 1'b0;

		// random code in appended chunks
		while (exec_count < 850) begin
			append_code($urandom_range(6, 30));
			if ($urandom_range(0, 3) == 0)
				load_word($urandom_range(prog_end, PDEPTH - 1), 8'($urandom));
			set_length(prog_end);
			run_steps($urandom_range(20, 80));
		end

		// one more chunk so the machine is running inside the program
		append_code(40);
		set_length(prog_end);

		// an open paren with no partner stops the machine for good
		lim = eff_len();
		if (!stopped && pc_now < lim) begin
			f = pc_now;
			load_word(f, pbie_pkg::CH_LPAREN);
			for (int i = f + 1; i < lim && i < f + 40; i++) load_word(i, 8'h20);
			for (int i = f + 40; i < lim; i++)
				if (prog_mem[i] == pbie_pkg::CH_RPAREN) load_word(i, 8'h20);
			run_steps(1);
		end
		repeat (3) exec_word();

		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_words.size() == 0);
		repeat (50) @(posedge clk);
		$display("covered %0d loads and %0d executed steps, %0d bytes emitted",
			load_count, exec_count, emit_count);
		$display("return stack reached depth %0d, fault state %0d", deepest, stopped);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// watchdog
	initial begin
		#200_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/pbie_pkg.sv
src/pbie_datapath.sv
src/pbie_ctrl.sv
src/pbrain_instruction_executor.sv
tb/tb_pbrain_instruction_executor.sv
